### rtl/rgb_to_hsv_converter_unit_assert.svh
// Assertion macros shared by the checker.
// Both macros are disabled while the synchronous reset is low.
`ifndef RGB_TO_HSV_CONVERTER_UNIT_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_UNIT_ASSERT_SVH

// Check that a condition holds at every clock edge.
`define RGB2HSV_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("rgb2hsv check failed");

// Check that a consequent holds in the same cycle as its antecedent.
`define RGB2HSV_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rgb2hsv check failed");

`endif

### rtl/rgb2hsv_pkg.sv
package rgb2hsv_pkg;

    localparam int PixW        = 8;
    localparam int QuoW        = 16;
    localparam int DenW        = 11;
    localparam int DivSteps    = 4;
    localparam int DivStages   = QuoW / DivSteps;
    // two prep stages, the divider stages, one output register
    localparam int PipeLatency = 2 + DivStages + 1;

    // one restoring divider lane: remainder, divisor, quotient so far,
    // and dividend bits still to shift in
    typedef struct packed {
        logic [DenW-1:0] rem;
        logic [DenW-1:0] den;
        logic [QuoW-1:0] quo;
        logic [QuoW-1:0] dvd;
    } t_div_lane;

    // payload carried down the divider pipeline
    typedef struct packed {
        logic            zero;
        logic            hue_full;
        logic [PixW-1:0] value;
        t_div_lane       hue;
        t_div_lane       sat;
    } t_div_data;

    // one quotient bit of restoring division
    function automatic t_div_lane div_step(t_div_lane l);
        logic [DenW:0] trial;
        t_div_lane     o;
        trial = {l.rem, l.dvd[QuoW-1]};
        o     = l;
        o.dvd = {l.dvd[QuoW-2:0], 1'b0};
        if (trial >= {1'b0, l.den}) begin
            o.rem = DenW'(trial - {1'b0, l.den});
            o.quo = {l.quo[QuoW-2:0], 1'b1};
        end else begin
            o.rem = trial[DenW-1:0];
            o.quo = {l.quo[QuoW-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

### rtl/rgb2hsv_prep.sv
module rgb2hsv_prep
    import rgb2hsv_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [PixW-1:0] i_red,
    input  logic [PixW-1:0] i_green,
    input  logic [PixW-1:0] i_blue,
    output logic            o_valid,
    output t_div_data       o_data
);

    // stage A: order the components with two conditional swaps
    logic            n_a_sw1, n_a_sw2;
    logic [PixW-1:0] n_a_hi, n_a_mid, n_a_lo, g1;
    logic            r_a_valid, r_a_sw1, r_a_sw2;
    logic [PixW-1:0] r_a_hi, r_a_mid, r_a_lo;

    always_comb begin
        n_a_sw1 = i_green < i_blue;
        g1      = n_a_sw1 ? i_blue  : i_green;
        n_a_lo  = n_a_sw1 ? i_green : i_blue;
        n_a_sw2 = i_red < g1;
        n_a_hi  = n_a_sw2 ? g1    : i_red;
        n_a_mid = n_a_sw2 ? i_red : g1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_sw1 <= n_a_sw1;
        r_a_sw2 <= n_a_sw2;
        r_a_hi  <= n_a_hi;
        r_a_mid <= n_a_mid;
        r_a_lo  <= n_a_lo;
    end

    // stage B: chroma, hue numerator magnitude, divider lane setup
    logic [PixW-1:0]      mn, chroma;
    logic [DenW-1:0]      c6;
    logic signed [11:0]   diff, c2s, c4s, c6s, num;
    logic [11:0]          num_abs;
    logic [DenW-1:0]      mag;
    logic [PixW+QuoW-1:0] sat_num;
    t_div_data            n_b_data;
    logic                 r_b_valid;
    t_div_data            r_b_data;

    always_comb begin
        mn      = (r_a_mid < r_a_lo) ? r_a_mid : r_a_lo;
        chroma  = r_a_hi - mn;
        c6      = {1'b0, chroma, 2'b00} + {2'b00, chroma, 1'b0};
        diff    = $signed({4'b0000, r_a_mid}) - $signed({4'b0000, r_a_lo});
        c2s     = $signed({3'b000, chroma, 1'b0});
        c4s     = $signed({2'b00, chroma, 2'b00});
        c6s     = $signed({1'b0, c6});
        // hue offset 6K follows from which swaps were taken
        unique case ({r_a_sw1, r_a_sw2})
            2'b00:   num = diff;
            2'b10:   num = diff - c6s;
            2'b01:   num = diff - c2s;
            default: num = diff + c4s;
        endcase
        num_abs = num[11] ? 12'(-num) : num;
        mag     = num_abs[DenW-1:0];
        sat_num = {chroma, {QuoW{1'b0}}} - {{QuoW{1'b0}}, chroma};

        n_b_data.zero     = (chroma == '0);
        n_b_data.hue_full = (mag == c6);
        n_b_data.value    = r_a_hi;
        n_b_data.hue.rem  = mag;
        n_b_data.hue.den  = c6;
        n_b_data.hue.quo  = '0;
        n_b_data.hue.dvd  = '0;
        // top bits of the saturation dividend are already below the divisor
        n_b_data.sat.rem  = {{(DenW-PixW){1'b0}}, sat_num[PixW+QuoW-1:QuoW]};
        n_b_data.sat.den  = {{(DenW-PixW){1'b0}}, r_a_hi};
        n_b_data.sat.quo  = '0;
        n_b_data.sat.dvd  = sat_num[QuoW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_data <= n_b_data;
    end

    assign o_valid = r_b_valid;
    assign o_data  = r_b_data;

endmodule

### rtl/rgb2hsv_div_stage.sv
module rgb2hsv_div_stage
    import rgb2hsv_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_div_data i_data,
    output logic      o_valid,
    output t_div_data o_data
);

    t_div_data n_data;
    logic      r_valid;
    t_div_data r_data;

    // advance both divider lanes by DivSteps quotient bits
    always_comb begin
        n_data = i_data;
        for (int i = 0; i < DivSteps; i++) begin
            n_data.hue = div_step(n_data.hue);
            n_data.sat = div_step(n_data.sat);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### rtl/rgb_to_hsv_converter_unit.sv
// Channel   Handshake                   Ports
// input     start, accepted if !busy    i_red_in, i_green_in, i_blue_in
// result    o_result_strobe, one cycle  o_hue_out, o_saturation_out, o_value_out
//
// One transaction enters every clock; busy is always low.
// Pipeline: two prep stages, four divider stages of four
// quotient bits each (both dividers side by side), one output register.
// Synchronous reset clears the valid bits only; nothing stalls downstream.
module rgb_to_hsv_converter_unit
    import rgb2hsv_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  logic [PixW-1:0] i_red_in,
    input  logic [PixW-1:0] i_green_in,
    input  logic [PixW-1:0] i_blue_in,
    output logic            o_result_strobe,
    output logic [QuoW-1:0] o_hue_out,
    output logic [QuoW-1:0] o_saturation_out,
    output logic [PixW-1:0] o_value_out
);

    logic      s_valid [0:DivStages];
    t_div_data s_data  [0:DivStages];

    assign busy = 1'b0;

    // sort components and set up the dividers
    rgb2hsv_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_red   (i_red_in),
        .i_green (i_green_in),
        .i_blue  (i_blue_in),
        .o_valid (s_valid[0]),
        .o_data  (s_data[0])
    );

    // divider pipeline
    for (genvar k = 0; k < DivStages; k++) begin : g_div
        rgb2hsv_div_stage u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[k]),
            .i_data  (s_data[k]),
            .o_valid (s_valid[k+1]),
            .o_data  (s_data[k+1])
        );
    end

    // output register: force gray to zero, saturate a full-turn hue
    logic            r_strobe;
    logic [QuoW-1:0] r_hue, r_sat, n_hue, n_sat;
    logic [PixW-1:0] r_value;

    always_comb begin
        priority if (s_data[DivStages].zero) begin
            n_hue = '0;
            n_sat = '0;
        end else if (s_data[DivStages].hue_full) begin
            n_hue = '1;
            n_sat = s_data[DivStages].sat.quo;
        end else begin
            n_hue = s_data[DivStages].hue.quo;
            n_sat = s_data[DivStages].sat.quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= s_valid[DivStages];
        end
    end

    always_ff @(posedge i_clk) begin
        r_hue   <= n_hue;
        r_sat   <= n_sat;
        r_value <= s_data[DivStages].value;
    end

    assign o_result_strobe  = r_strobe;
    assign o_hue_out        = r_hue;
    assign o_saturation_out = r_sat;
    assign o_value_out      = r_value;

endmodule

### rtl/rgb2hsv_checker.sv
`include "rgb_to_hsv_converter_unit_assert.svh"

module rgb2hsv_checker
    import rgb2hsv_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            start,
    input logic            busy,
    input logic [PixW-1:0] i_red_in,
    input logic [PixW-1:0] i_green_in,
    input logic [PixW-1:0] i_blue_in,
    input logic            o_result_strobe,
    input logic [QuoW-1:0] o_hue_out,
    input logic [QuoW-1:0] o_saturation_out,
    input logic [PixW-1:0] o_value_out
);

    // every strobe goes back to an accepted transaction at fixed latency
    `RGB2HSV_ASSERT_IMPL(a_no_invented, o_result_strobe, $past(start && !busy, PipeLatency))

    // value is no smaller than any component of its transaction
    `RGB2HSV_ASSERT_IMPL(a_value_max, o_result_strobe, (o_value_out >= $past(i_red_in, PipeLatency)) && (o_value_out >= $past(i_green_in, PipeLatency)) && (o_value_out >= $past(i_blue_in, PipeLatency)))

    // black gives zero hue and saturation
    `RGB2HSV_ASSERT_IMPL(a_black_zero, o_result_strobe && (o_value_out == '0), (o_hue_out == '0) && (o_saturation_out == '0))

    // gray inputs give zero hue and saturation
    `RGB2HSV_ASSERT_IMPL(a_gray_zero, o_result_strobe && ($past(i_red_in, PipeLatency) == $past(i_green_in, PipeLatency)) && ($past(i_green_in, PipeLatency) == $past(i_blue_in, PipeLatency)), (o_hue_out == '0) && (o_saturation_out == '0))

endmodule

bind rgb_to_hsv_converter_unit rgb2hsv_checker u_rgb2hsv_checker (.*);

### dv/rgb_to_hsv_converter_unit_tb.sv
module rgb_to_hsv_converter_unit_tb;
    import rgb2hsv_pkg::*;

    typedef struct packed {
        logic [PixW-1:0] red;
        logic [PixW-1:0] green;
        logic [PixW-1:0] blue;
        logic            drain;   // wait for all results before sending
    } t_pixel;

    typedef struct packed {
        logic [QuoW-1:0] hue;
        logic [QuoW-1:0] sat;
        logic [PixW-1:0] val;
    } t_hsv;

    logic            i_clk   = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            start   = 1'b0;
    logic            busy;
    logic [PixW-1:0] red_in   = '0;
    logic [PixW-1:0] green_in = '0;
    logic [PixW-1:0] blue_in  = '0;
    logic            o_result_strobe;
    logic [QuoW-1:0] o_hue_out;
    logic [QuoW-1:0] o_saturation_out;
    logic [PixW-1:0] o_value_out;

    t_pixel pixel_q[$];
    t_hsv   hsv_expected[$];
    t_pixel drive_px;
    t_hsv   got_hsv;
    t_hsv   want_hsv;
    logic   issued     = 1'b0;
    int     gap_left   = 0;
    int     burst_left = 0;
    int     gap_pick;
    int     n_sent     = 0;
    int     n_checked  = 0;
    int     n_errors   = 0;

    rgb_to_hsv_converter_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_red_in         (red_in),
        .i_green_in       (green_in),
        .i_blue_in        (blue_in),
        .o_result_strobe  (o_result_strobe),
        .o_hue_out        (o_hue_out),
        .o_saturation_out (o_saturation_out),
        .o_value_out      (o_value_out)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Compute hue, saturation and value of one pixel in exact integer math
    function automatic t_hsv predict_hsv(logic [PixW-1:0] r_in, logic [PixW-1:0] g_in,
                                         logic [PixW-1:0] b_in);
        int              r, g, b, k6, t, mn, c, num;
        longint unsigned mag, hue, sat;
        t_hsv            res;
        r  = r_in;
        g  = g_in;
        b  = b_in;
        k6 = 0;
        // order the components, tracking the hue offset
        if (g < b) begin
            t  = b;
            b  = g;
            g  = t;
            k6 = -6;
        end
        if (r < g) begin
            t  = r;
            r  = g;
            g  = t;
            k6 = -2 - k6;
        end
        mn = (g < b) ? g : b;
        c  = r - mn;
        if (c == 0) begin
            hue = 0;
            sat = 0;
        end else begin
            num = k6 * c + (g - b);
            mag = (num < 0) ? longint'(-num) : longint'(num);
            hue = (mag << 16) / longint'(6 * c);
            if (hue > 65535)
                hue = 65535;
            sat = (longint'(c) * 65535) / longint'(r);
            if (sat > 65535)
                sat = 65535;
        end
        res.hue = hue[QuoW-1:0];
        res.sat = sat[QuoW-1:0];
        res.val = r[PixW-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        n_errors++;
    endtask

    task automatic add_pixel(input int r, input int g, input int b, input bit drain);
        t_pixel px;
        px.red   = r[PixW-1:0];
        px.green = g[PixW-1:0];
        px.blue  = b[PixW-1:0];
        px.drain = drain;
        pixel_q.push_back(px);
    endtask

    // Drive the next pixel at the falling edge; hold while not taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !issued) begin
            // hold the current transaction
        end else if (gap_left > 0) begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (pixel_q.size() == 0) begin
            start <= 1'b0;
        end else if (pixel_q[0].drain && hsv_expected.size() != 0) begin
            start <= 1'b0;
        end else begin
            drive_px = pixel_q.pop_front();
            red_in   <= drive_px.red;
            green_in <= drive_px.green;
            blue_in  <= drive_px.blue;
            start    <= 1'b1;
            // pick the idle gap after this transaction
            if (burst_left > 0) begin
                burst_left <= burst_left - 1;
                gap_left   <= 0;
            end else begin
                gap_pick = $urandom_range(0, 99);
                if (gap_pick < 55)
                    gap_left <= 0;
                else if (gap_pick < 85)
                    gap_left <= $urandom_range(1, 3);
                else if (gap_pick < 95)
                    gap_left <= $urandom_range(4, 10);
                else if (gap_pick < 98)
                    gap_left <= $urandom_range(20, 40);
                else begin
                    gap_left   <= 0;
                    burst_left <= $urandom_range(20, 60);
                end
            end
        end
    end

    // Record accepted transactions and check results at the rising edge
    always @(posedge i_clk) begin
        issued <= i_rst_n && start && !busy;
        if (i_rst_n) begin
            if (o_result_strobe !== 1'b0) begin
                got_hsv = '{o_hue_out, o_saturation_out, o_value_out};
                if (hsv_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected result hue=%0d sat=%0d val=%0d",
                                              o_hue_out, o_saturation_out, o_value_out));
                end else begin
                    want_hsv = hsv_expected.pop_front();
                    if (got_hsv.hue !== want_hsv.hue)
                        report_mismatch($sformatf("result %0d hue got %0d expected %0d",
                                                  n_checked, got_hsv.hue, want_hsv.hue));
                    if (got_hsv.sat !== want_hsv.sat)
                        report_mismatch($sformatf("result %0d saturation got %0d expected %0d",
                                                  n_checked, got_hsv.sat, want_hsv.sat));
                    if (got_hsv.val !== want_hsv.val)
                        report_mismatch($sformatf("result %0d value got %0d expected %0d",
                                                  n_checked, got_hsv.val, want_hsv.val));
                    n_checked++;
                end
            end
            if (start && !busy) begin
                hsv_expected.push_back(predict_hsv(red_in, green_in, blue_in));
                n_sent++;
            end
        end
    end

    // Build the stimulus, run it through, and report
    initial begin
        int sel, base, i;
        int r, g, b;

        // grays, primaries, secondaries
        add_pixel(0, 0, 0, 1'b0);
        add_pixel(255, 255, 255, 1'b0);
        add_pixel(128, 128, 128, 1'b0);
        add_pixel(1, 1, 1, 1'b0);
        add_pixel(255, 0, 0, 1'b0);
        add_pixel(0, 255, 0, 1'b0);
        add_pixel(0, 0, 255, 1'b0);
        add_pixel(255, 255, 0, 1'b0);
        add_pixel(0, 255, 255, 1'b0);
        add_pixel(255, 0, 255, 1'b0);
        // hue just short of a full turn, minimum chroma
        add_pixel(255, 0, 1, 1'b0);
        add_pixel(0, 0, 1, 1'b0);
        add_pixel(1, 0, 0, 1'b0);
        add_pixel(0, 1, 0, 1'b0);
        add_pixel(255, 254, 254, 1'b0);
        // every ordering of three distinct components
        add_pixel(10, 20, 30, 1'b0);
        add_pixel(10, 30, 20, 1'b0);
        add_pixel(20, 10, 30, 1'b0);
        add_pixel(20, 30, 10, 1'b0);
        add_pixel(30, 10, 20, 1'b0);
        add_pixel(30, 20, 10, 1'b0);
        // two components tied at the maximum
        add_pixel(200, 200, 100, 1'b0);
        add_pixel(200, 100, 200, 1'b0);
        add_pixel(100, 200, 200, 1'b0);

        for (i = 0; i < 950; i++) begin
            sel = $urandom_range(0, 99);
            r   = $urandom_range(0, 255);
            g   = $urandom_range(0, 255);
            b   = $urandom_range(0, 255);
            if (sel < 60) begin
                // uniform content
            end else if (sel < 72) begin
                case ($urandom_range(0, 2))
                    0: g = r;
                    1: b = r;
                    default: b = g;
                endcase
            end else if (sel < 78) begin
                g = r;
                b = r;
            end else if (sel < 88) begin
                r = ($urandom_range(0, 1) != 0) ? 255 - $urandom_range(0, 1)
                                                : $urandom_range(0, 1);
                g = ($urandom_range(0, 1) != 0) ? 255 - $urandom_range(0, 1)
                                                : $urandom_range(0, 1);
                b = ($urandom_range(0, 1) != 0) ? 255 - $urandom_range(0, 1)
                                                : $urandom_range(0, 1);
            end else begin
                // small chroma around a random base
                base = $urandom_range(2, 253);
                r    = base + $urandom_range(0, 4) - 2;
                g    = base + $urandom_range(0, 4) - 2;
                b    = base + $urandom_range(0, 4) - 2;
            end
            add_pixel(r, g, b, (i % 237) == 0);
        end

        // hold reset, then release it at a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pixel_q.size() != 0 || start || hsv_expected.size() != 0)
            @(posedge i_clk);
        repeat (PipeLatency + 4) @(posedge i_clk);

        if (hsv_expected.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", hsv_expected.size()));
        $display("Summary: %0d pixels sent, %0d results checked", n_sent, n_checked);
        $display("Covered grays, primaries, every ordering, ties, corners and random pixels");
        if (n_errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Guard against a hang
    initial begin
        #5000000;
        $display("Timeout with %0d results outstanding", hsv_expected.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
